>>> rtl/ost_pkg.sv
`default_nettype none

package ost_pkg;

    localparam int RAW_W       = 64;
    localparam int KEPT_BITS   = 49;
    localparam int RUN_LIMIT   = 5;
    localparam int RUN_W       = 3;
    localparam int STEP_BITS   = 7;
    localparam int STEP_COUNT  = KEPT_BITS / STEP_BITS;
    localparam int STEP_CNT_W  = $clog2(STEP_COUNT);
    localparam int ID_W        = 32;
    localparam int SIDE_POS    = 32;
    localparam int QTY_POS     = 33;
    localparam int VALUE_POS   = 41;
    localparam int VALUE_W     = 8;
    localparam int SUM_W       = 40;
    localparam int COUNT_W     = 32;
    localparam int DEF_ID_BITS = 16;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic               sell;
        logic [VALUE_W-1:0] value;
    } t_order;

    typedef struct packed {
        logic               sell_seen;
        logic               buy_seen;
        logic [VALUE_W-1:0] lowest_sell;
        logic [VALUE_W-1:0] highest_buy;
        logic [SUM_W-1:0]   sum;
        logic [COUNT_W-1:0] count;
    } t_rec;

    localparam t_rec REC_RESET = t_rec'{
        sell_seen:   1'b0,
        buy_seen:    1'b0,
        lowest_sell: {VALUE_W{1'b1}},
        highest_buy: {VALUE_W{1'b0}},
        sum:         {SUM_W{1'b0}},
        count:       {COUNT_W{1'b0}}
    };

endpackage

`default_nettype wire

>>> rtl/ost_front.sv
`default_nettype none

module ost_front (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic [ost_pkg::RAW_W-1:0] i_raw_packet,
    input  wire logic                     i_clr_done,
    input  wire logic                     i_fifo_full,
    output logic                          o_push,
    output ost_pkg::t_order               o_order
);
    import ost_pkg::*;

    localparam logic [1:0] FE_IDLE = 2'd0;
    localparam logic [1:0] FE_WORK = 2'd1;
    localparam logic [1:0] FE_PUSH = 2'd2;

    localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(STEP_COUNT - 1);

    logic [1:0]            r_state, n_state;
    logic [STEP_CNT_W-1:0] r_cnt, n_cnt;
    logic [RAW_W-1:0]      r_raw, n_raw;
    logic [RUN_W-1:0]      r_run, n_run;
    logic [KEPT_BITS-1:0]  r_kept, n_kept;

    logic [RAW_W-1:0]     s_raw;
    logic [RUN_W-1:0]     s_run;
    logic [KEPT_BITS-1:0] s_kept;

    // Several unstuffing steps per cycle: the raw word shifts down as bits are used,
    // by two where a run of five ones forces the following bit to be dropped.
    always_comb begin
        s_raw  = r_raw;
        s_run  = r_run;
        s_kept = r_kept;
        for (int s = 0; s < STEP_BITS; s++) begin
            s_kept = {s_raw[0], s_kept[KEPT_BITS-1:1]};
            if (s_raw[0]) begin
                s_run = s_run + RUN_W'(1);
            end else begin
                s_run = '0;
            end
            if (s_run == RUN_W'(RUN_LIMIT)) begin
                s_raw = s_raw >> 2;
                s_run = '0;
            end else begin
                s_raw = s_raw >> 1;
            end
        end
    end

    assign o_ready = (r_state == FE_IDLE) && i_clr_done;
    assign o_push  = (r_state == FE_PUSH) && !i_fifo_full;
    assign o_order = t_order'{
        id:    r_kept[ID_W-1:0],
        sell:  r_kept[SIDE_POS],
        value: r_kept[VALUE_POS +: VALUE_W]
    };

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_raw   = r_raw;
        n_run   = r_run;
        n_kept  = r_kept;
        unique case (r_state)
            FE_IDLE: begin
                if (i_valid && o_ready) begin
                    n_raw   = i_raw_packet;
                    n_run   = '0;
                    n_cnt   = '0;
                    n_state = FE_WORK;
                end
            end
            FE_WORK: begin
                n_raw  = s_raw;
                n_run  = s_run;
                n_kept = s_kept;
                n_cnt  = r_cnt + STEP_CNT_W'(1);
                if (r_cnt == LAST_STEP) begin
                    n_state = FE_PUSH;
                end
            end
            FE_PUSH: begin
                if (!i_fifo_full) begin
                    n_state = FE_IDLE;
                end
            end
            default: begin
                n_state = FE_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FE_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_raw  <= n_raw;
        r_run  <= n_run;
        r_kept <= n_kept;
    end

endmodule

`default_nettype wire

>>> rtl/ost_fifo.sv
`default_nettype none

module ost_fifo (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire ost_pkg::t_order i_data,
    output logic              o_full,
    input  wire logic         i_pop,
    output ost_pkg::t_order   o_data,
    output logic              o_empty
);
    import ost_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_order           r_buf [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_buf[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
        end
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/ost_back.sv
`default_nettype none

module ost_back #(
    parameter int ID_BITS = ost_pkg::DEF_ID_BITS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_empty,
    input  wire ost_pkg::t_order             i_order,
    output logic                             o_pop,
    output logic                             o_clr_done,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [ost_pkg::ID_W-1:0]         o_stock_id,
    output logic                             o_id_out_of_range,
    output logic                             o_has_sell,
    output logic                             o_has_buy,
    output logic [ost_pkg::VALUE_W-1:0]      o_min_sell,
    output logic [ost_pkg::VALUE_W-1:0]      o_max_buy,
    output logic [ost_pkg::SUM_W-1:0]        o_value_sum,
    output logic [ost_pkg::COUNT_W-1:0]      o_order_count
);
    import ost_pkg::*;

    localparam int TABLE_DEPTH = 1 << ID_BITS;

    localparam logic [1:0] BK_CLEAR = 2'd0;
    localparam logic [1:0] BK_IDLE  = 2'd1;
    localparam logic [1:0] BK_READ  = 2'd2;
    localparam logic [1:0] BK_OUT   = 2'd3;

    t_rec r_mem [TABLE_DEPTH];

    logic [1:0]         r_state;
    logic [ID_BITS-1:0] r_clr_addr;
    logic               r_clr_done;
    t_order             r_order;
    t_rec               r_rd_data;
    t_rec               n_rec;
    logic [SUM_W:0]     s_sum;
    logic               s_in_range;
    logic               s_we;
    logic [ID_BITS-1:0] s_wa;
    t_rec               s_wd;

    logic [ID_W-1:0]    r_o_stock_id;
    logic               r_o_oor;
    logic               r_o_has_sell;
    logic               r_o_has_buy;
    logic [VALUE_W-1:0] r_o_min_sell;
    logic [VALUE_W-1:0] r_o_max_buy;
    logic [SUM_W-1:0]   r_o_value_sum;
    logic [COUNT_W-1:0] r_o_order_count;

    assign s_in_range = (i_order.id[ID_W-1:ID_BITS] == '0);
    assign o_pop      = (r_state == BK_IDLE) && !i_empty;
    assign o_clr_done = r_clr_done;
    assign o_valid    = (r_state == BK_OUT);

    always_comb begin
        n_rec = r_rd_data;
        if (r_order.sell) begin
            n_rec.sell_seen = 1'b1;
            if (r_order.value < n_rec.lowest_sell) begin
                n_rec.lowest_sell = r_order.value;
            end
        end else begin
            n_rec.buy_seen = 1'b1;
            if (r_order.value > n_rec.highest_buy) begin
                n_rec.highest_buy = r_order.value;
            end
        end
        s_sum = {1'b0, r_rd_data.sum} + (SUM_W + 1)'(r_order.value);
        n_rec.sum = s_sum[SUM_W] ? {SUM_W{1'b1}} : s_sum[SUM_W-1:0];
        if (r_rd_data.count != {COUNT_W{1'b1}}) begin
            n_rec.count = r_rd_data.count + COUNT_W'(1);
        end
    end

    assign s_we = (r_state == BK_CLEAR) || (r_state == BK_READ);
    assign s_wa = (r_state == BK_CLEAR) ? r_clr_addr : r_order.id[ID_BITS-1:0];
    assign s_wd = (r_state == BK_CLEAR) ? REC_RESET : n_rec;

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_mem[s_wa] <= s_wd;
        end
        r_rd_data <= r_mem[i_order.id[ID_BITS-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BK_CLEAR;
            r_clr_addr <= '0;
            r_clr_done <= 1'b0;
        end else begin
            unique case (r_state)
                BK_CLEAR: begin
                    r_clr_addr <= r_clr_addr + ID_BITS'(1);
                    if (r_clr_addr == {ID_BITS{1'b1}}) begin
                        r_clr_done <= 1'b1;
                        r_state    <= BK_IDLE;
                    end
                end
                BK_IDLE: begin
                    if (o_pop) begin
                        r_state <= s_in_range ? BK_READ : BK_OUT;
                    end
                end
                BK_READ: begin
                    r_state <= BK_OUT;
                end
                BK_OUT: begin
                    if (i_ready) begin
                        r_state <= BK_IDLE;
                    end
                end
                default: begin
                    r_state <= BK_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_order <= i_order;
        end
        if (o_pop && !s_in_range) begin
            r_o_stock_id    <= i_order.id;
            r_o_oor         <= 1'b1;
            r_o_has_sell    <= 1'b0;
            r_o_has_buy     <= 1'b0;
            r_o_min_sell    <= '0;
            r_o_max_buy     <= '0;
            r_o_value_sum   <= '0;
            r_o_order_count <= '0;
        end else if (r_state == BK_READ) begin
            r_o_stock_id    <= r_order.id;
            r_o_oor         <= 1'b0;
            r_o_has_sell    <= n_rec.sell_seen;
            r_o_has_buy     <= n_rec.buy_seen;
            r_o_min_sell    <= n_rec.sell_seen ? n_rec.lowest_sell : '0;
            r_o_max_buy     <= n_rec.buy_seen ? n_rec.highest_buy : '0;
            r_o_value_sum   <= n_rec.sum;
            r_o_order_count <= n_rec.count;
        end
    end

    assign o_stock_id        = r_o_stock_id;
    assign o_id_out_of_range = r_o_oor;
    assign o_has_sell        = r_o_has_sell;
    assign o_has_buy         = r_o_has_buy;
    assign o_min_sell        = r_o_min_sell;
    assign o_max_buy         = r_o_max_buy;
    assign o_value_sum       = r_o_value_sum;
    assign o_order_count     = r_o_order_count;

    a_clear_stays_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_done |=> r_clr_done)
        else $error("Table clear finished flag dropped.");

    a_pop_after_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> r_clr_done)
        else $error("Order word taken before the table clear finished.");

    a_oor_zero_stats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_id_out_of_range) |-> (!o_has_sell && !o_has_buy &&
            o_min_sell == '0 && o_max_buy == '0 &&
            o_value_sum == '0 && o_order_count == '0))
        else $error("Out of range result carries statistics.");

    a_updated_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_id_out_of_range) |->
            ((o_has_sell || o_has_buy) && o_order_count != '0))
        else $error("Updated record shows no order.");

endmodule

`default_nettype wire

>>> rtl/order_stats_table.sv
`default_nettype none

// Per-stock order statistics. Each input word is a 64-bit bit-stuffed packet that is
// unstuffed (a bit following five ones is dropped) into a stock id, a side flag and an
// 8-bit value; the record of that stock is updated and the updated record is returned
// as one output word. Ids at or above 2**ID_BITS are flagged and leave the table alone.
// After reset the table is cleared one entry per cycle, and no input word is taken until
// the clear is done. The unstuffer handles seven bits per cycle, and the front end takes
// no new word until it has pushed the last one into a two-word queue. The table update
// behind the queue reads, then updates and writes, then delivers each word; an
// out-of-range id skips the update and write. The front end can unstuff the next word
// while the table update works on earlier ones from the queue.
module order_stats_table #(
    parameter int ID_BITS = ost_pkg::DEF_ID_BITS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [ost_pkg::RAW_W-1:0]    i_raw_packet,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [ost_pkg::ID_W-1:0]          o_stock_id,
    output logic                              o_id_out_of_range,
    output logic                              o_has_sell,
    output logic                              o_has_buy,
    output logic [ost_pkg::VALUE_W-1:0]       o_min_sell,
    output logic [ost_pkg::VALUE_W-1:0]       o_max_buy,
    output logic [ost_pkg::SUM_W-1:0]         o_value_sum,
    output logic [ost_pkg::COUNT_W-1:0]       o_order_count
);
    import ost_pkg::*;

    logic   s_push;
    logic   s_full;
    logic   s_pop;
    logic   s_empty;
    logic   s_clr_done;
    t_order s_push_order;
    t_order s_head_order;

    ost_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_raw_packet (i_raw_packet),
        .i_clr_done   (s_clr_done),
        .i_fifo_full  (s_full),
        .o_push       (s_push),
        .o_order      (s_push_order)
    );

    ost_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .i_data  (s_push_order),
        .o_full  (s_full),
        .i_pop   (s_pop),
        .o_data  (s_head_order),
        .o_empty (s_empty)
    );

    ost_back #(
        .ID_BITS (ID_BITS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_empty           (s_empty),
        .i_order           (s_head_order),
        .o_pop             (s_pop),
        .o_clr_done        (s_clr_done),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_stock_id        (o_stock_id),
        .o_id_out_of_range (o_id_out_of_range),
        .o_has_sell        (o_has_sell),
        .o_has_buy         (o_has_buy),
        .o_min_sell        (o_min_sell),
        .o_max_buy         (o_max_buy),
        .o_value_sum       (o_value_sum),
        .o_order_count     (o_order_count)
    );

endmodule

`default_nettype wire

>>> verif/tb_top.sv
module tb_top;

    localparam int ID_BITS    = ost_pkg::DEF_ID_BITS;
    localparam int TBL_DEPTH  = 1 << ID_BITS;
    localparam int TBL_LAST   = TBL_DEPTH - 1;
    localparam int RAND_ITEMS = 1600;
    localparam int CALM_TAIL  = 300;
    localparam logic SIDE_SELL = 1'b1;
    localparam logic SIDE_BUY  = 1'b0;
    localparam logic [ost_pkg::SUM_W-1:0]   SUM_MAX   = '1;
    localparam logic [ost_pkg::COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [ost_pkg::RAW_W-1:0] raw;
        logic [4:0]                gap;
        logic                      drain;
    } t_packet;

    typedef struct packed {
        logic [ost_pkg::ID_W-1:0]    stock_id;
        logic                        out_of_range;
        logic                        has_sell;
        logic                        has_buy;
        logic [ost_pkg::VALUE_W-1:0] min_sell;
        logic [ost_pkg::VALUE_W-1:0] max_buy;
        logic [ost_pkg::SUM_W-1:0]   value_sum;
        logic [ost_pkg::COUNT_W-1:0] order_count;
    } t_stats;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_valid = 1'b0;
    logic                              o_ready;
    logic [ost_pkg::RAW_W-1:0]         i_raw_packet = '0;
    logic                              o_valid;
    logic                              i_ready = 1'b0;
    logic [ost_pkg::ID_W-1:0]          o_stock_id;
    logic                              o_id_out_of_range;
    logic                              o_has_sell;
    logic                              o_has_buy;
    logic [ost_pkg::VALUE_W-1:0]       o_min_sell;
    logic [ost_pkg::VALUE_W-1:0]       o_max_buy;
    logic [ost_pkg::SUM_W-1:0]         o_value_sum;
    logic [ost_pkg::COUNT_W-1:0]       o_order_count;

    ost_pkg::t_rec stock_tbl [TBL_DEPTH];
    t_packet       packets_pending [$];
    t_stats        stats_due [$];
    int            gap_left = 0;
    int            stall_left = 0;
    int            words_out = 0;
    int            total_items = 0;
    int            fail_cnt = 0;

    order_stats_table #(
        .ID_BITS(ID_BITS)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_raw_packet     (i_raw_packet),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_stock_id       (o_stock_id),
        .o_id_out_of_range(o_id_out_of_range),
        .o_has_sell       (o_has_sell),
        .o_has_buy        (o_has_buy),
        .o_min_sell       (o_min_sell),
        .o_max_buy        (o_max_buy),
        .o_value_sum      (o_value_sum),
        .o_order_count    (o_order_count)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic [ost_pkg::KEPT_BITS-1:0] unstuff(
        input logic [ost_pkg::RAW_W-1:0] raw
    );
        logic [ost_pkg::KEPT_BITS-1:0] kept;
        int pos;
        int run;
        kept = '0;
        pos = 0;
        run = 0;
        for (int n = 0; n < ost_pkg::KEPT_BITS; n++) begin
            kept[n] = raw[pos];
            run = raw[pos] ? run + 1 : 0;
            if (run == ost_pkg::RUN_LIMIT) begin
                pos += 2;
                run = 0;
            end else begin
                pos += 1;
            end
        end
        return kept;
    endfunction

    // Every skipped bit and every bit past the end keeps a random value.
    function automatic logic [ost_pkg::RAW_W-1:0] stuff(
        input logic [ost_pkg::KEPT_BITS-1:0] word
    );
        logic [ost_pkg::RAW_W-1:0] raw;
        int pos;
        int run;
        raw = {$urandom, $urandom};
        pos = 0;
        run = 0;
        for (int n = 0; n < ost_pkg::KEPT_BITS; n++) begin
            raw[pos] = word[n];
            run = word[n] ? run + 1 : 0;
            if (run == ost_pkg::RUN_LIMIT) begin
                pos += 2;
                run = 0;
            end else begin
                pos += 1;
            end
        end
        return raw;
    endfunction

    function automatic logic [ost_pkg::KEPT_BITS-1:0] order_word(
        input logic [ost_pkg::ID_W-1:0]    id,
        input logic                        side,
        input logic [7:0]                  qty,
        input logic [ost_pkg::VALUE_W-1:0] value
    );
        return {value, qty, side, id};
    endfunction

    task automatic apply_order(input logic [ost_pkg::RAW_W-1:0] raw);
        logic [ost_pkg::KEPT_BITS-1:0] word;
        logic [ost_pkg::ID_W-1:0]      id;
        logic                          sell;
        logic [ost_pkg::VALUE_W-1:0]   value;
        ost_pkg::t_rec                 rec;
        t_stats                        stats;
        word = unstuff(raw);
        id = word[ost_pkg::ID_W-1:0];
        sell = word[ost_pkg::SIDE_POS];
        value = word[ost_pkg::VALUE_POS +: ost_pkg::VALUE_W];
        stats = '0;
        stats.stock_id = id;
        if ((id >> ID_BITS) != '0) begin
            stats.out_of_range = 1'b1;
        end else begin
            rec = stock_tbl[id[ID_BITS-1:0]];
            if (sell == SIDE_SELL) begin
                rec.sell_seen = 1'b1;
                if (value < rec.lowest_sell) begin
                    rec.lowest_sell = value;
                end
            end else begin
                rec.buy_seen = 1'b1;
                if (value > rec.highest_buy) begin
                    rec.highest_buy = value;
                end
            end
            if ({1'b0, rec.sum} + value > {1'b0, SUM_MAX}) begin
                rec.sum = SUM_MAX;
            end else begin
                rec.sum = rec.sum + value;
            end
            if (rec.count != COUNT_MAX) begin
                rec.count = rec.count + 1'b1;
            end
            stock_tbl[id[ID_BITS-1:0]] = rec;
            stats.has_sell = rec.sell_seen;
            stats.has_buy = rec.buy_seen;
            stats.min_sell = rec.sell_seen ? rec.lowest_sell : '0;
            stats.max_buy = rec.buy_seen ? rec.highest_buy : '0;
            stats.value_sum = rec.sum;
            stats.order_count = rec.count;
        end
        stats_due = {stats_due, stats};
    endtask

    task automatic add_packet(
        input logic [ost_pkg::RAW_W-1:0] raw,
        input int                        gap,
        input logic                      drain
    );
        t_packet pkt;
        pkt.raw = raw;
        pkt.gap = gap[4:0];
        pkt.drain = drain;
        packets_pending = {packets_pending, pkt};
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_cnt++;
        end
    endtask

    always @(posedge i_clk) begin : drive_packets
        logic    fire;
        t_packet nxt;
        fire = i_valid && o_ready;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (fire) begin
                apply_order(i_raw_packet);
            end
            if (!i_valid || fire) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (packets_pending.size() != 0
                             && !(packets_pending[0].drain && stats_due.size() != 0)) begin
                    nxt = packets_pending.pop_front();
                    i_raw_packet <= nxt.raw;
                    i_valid <= 1'b1;
                    gap_left = int'(nxt.gap);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_stats
        t_stats want;
        logic   calm;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (stats_due.size() == 0) begin
                    $error("unexpected word with stock_id %0h", o_stock_id);
                    fail_cnt++;
                end else begin
                    want = stats_due.pop_front();
                    check_field("stock_id", want.stock_id, o_stock_id);
                    check_field("id_out_of_range", want.out_of_range, o_id_out_of_range);
                    check_field("has_sell", want.has_sell, o_has_sell);
                    check_field("has_buy", want.has_buy, o_has_buy);
                    check_field("min_sell", want.min_sell, o_min_sell);
                    check_field("max_buy", want.max_buy, o_max_buy);
                    check_field("value_sum", want.value_sum, o_value_sum);
                    check_field("order_count", want.order_count, o_order_count);
                end
                words_out++;
            end
            calm = (words_out + CALM_TAIL >= total_items) || ((words_out / 64) % 4 == 3);
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 17);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        logic [ost_pkg::RAW_W-1:0]   raw;
        logic [ost_pkg::ID_W-1:0]    id;
        logic [ost_pkg::VALUE_W-1:0] value;
        logic                        bursty;
        int                          gap;
        foreach (stock_tbl[k]) begin
            stock_tbl[k] = ost_pkg::REC_RESET;
        end

        add_packet(stuff(order_word(0, SIDE_BUY, 8'h00, 8'h00)), 0, 1'b0);
        add_packet(stuff(order_word(0, SIDE_BUY, 8'hFF, 8'hFF)), 0, 1'b0);
        add_packet(stuff(order_word(0, SIDE_SELL, 8'h00, 8'hFF)), 0, 1'b0);
        add_packet(stuff(order_word(0, SIDE_SELL, 8'hFF, 8'h00)), 0, 1'b0);
        add_packet(stuff(order_word(0, SIDE_SELL, 8'h5A, 8'h80)), 0, 1'b0);
        add_packet(stuff(order_word(0, SIDE_BUY, 8'hA5, 8'h10)), 3, 1'b0);
        add_packet(stuff(order_word(TBL_LAST, SIDE_SELL, 8'hFF, 8'hFF)), 0, 1'b0);
        add_packet(stuff(order_word(TBL_LAST, SIDE_SELL, 8'hFF, 8'hFF)), 0, 1'b0);
        add_packet(stuff(order_word(TBL_LAST, SIDE_BUY, 8'hFF, 8'hFF)), 0, 1'b0);
        add_packet(stuff(order_word(TBL_DEPTH, SIDE_SELL, 8'h00, 8'h01)), 0, 1'b0);
        add_packet(stuff(order_word('1, SIDE_SELL, 8'hFF, 8'hFF)), 0, 1'b0);
        add_packet(stuff(order_word('1, SIDE_BUY, 8'h00, 8'h00)), 0, 1'b0);
        add_packet('1, 0, 1'b0);
        add_packet('0, 7, 1'b0);
        add_packet({$urandom, $urandom}, 0, 1'b0);
        for (int n = 0; n < 5; n++) begin
            add_packet(stuff(order_word(7, 1'($urandom_range(0, 1)), 8'($urandom),
                                        8'($urandom))), 0, 1'b0);
        end
        add_packet(stuff(order_word(7, SIDE_SELL, 8'h00, 8'hFF)), 0, 1'b1);
        add_packet(stuff(order_word(TBL_DEPTH - 2, SIDE_BUY, 8'h3C, 8'h7E)), 0, 1'b0);

        bursty = 1'b0;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % 50 == 0) begin
                bursty = $urandom_range(0, 3) != 0;
            end
            gap = 0;
            if (bursty && n < RAND_ITEMS - CALM_TAIL && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 18);
            end
            if ($urandom_range(0, 4) == 0) begin
                raw = {$urandom, $urandom};
            end else begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6, 7, 8, 9: id = $urandom_range(0, 7);
                    10, 11, 12, 13, 14:           id = $urandom_range(0, TBL_LAST);
                    15:                           id = TBL_LAST;
                    16:                           id = TBL_DEPTH;
                    17:                           id = '1;
                    default:                      id = $urandom;
                endcase
                value = 8'($urandom);
                if ($urandom_range(0, 7) == 0) begin
                    value = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                end
                raw = stuff(order_word(id, 1'($urandom_range(0, 1)), 8'($urandom), value));
            end
            add_packet(raw, gap, n == RAND_ITEMS / 2);
        end
        total_items = packets_pending.size();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (packets_pending.size() != 0 || i_valid) begin
            @(posedge i_clk);
        end
        while (stats_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (64) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin : watchdog
        #8000000;
        $display("tb: failure");
        $finish;
    end

endmodule
